[rtl/core/hhfp_pkg.sv]
// Package for the HTTP header field parser.
// Holds the sizing constants, phase and result types and character codes.
// No dependencies.
`default_nettype none

package hhfp_pkg;

    // Largest header block in bytes; the position counter can hold this value
    localparam int unsigned MAX_BLOCK_BYTES = 8192;
    localparam int unsigned POS_W           = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned FIELD_W         = 13;
    localparam int unsigned KIND_W          = 2;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [KIND_W-1:0]  kind_t;

    // Result kinds
    localparam kind_t KIND_FIELD    = 2'd0;
    localparam kind_t KIND_DONE     = 2'd1;
    localparam kind_t KIND_OVERFLOW = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_NAME_BEGIN,
        PH_NAME,
        PH_OWS,
        PH_VALUE,
        PH_NEXT,
        PH_STOPPED
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   prev_was_cr;
        pos_t   byte_position;
        pos_t   name_start;
        pos_t   name_stop;
        pos_t   value_start;
    } parse_state_t;

    typedef struct packed {
        kind_t  kind;
        field_t name_offset;
        field_t name_length;
        field_t value_offset;
        field_t value_length;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:         PH_BEGIN,
        prev_was_cr:   1'b0,
        byte_position: '0,
        name_start:    '0,
        name_stop:     '0,
        value_start:   '0
    };

    // Position to reported field width: zero-extend or keep the low bits
    function automatic field_t to_field(input pos_t x);
        logic [31:0] w;
        w = 32'(x);
        return w[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/hhfp_ifs.sv]
// Valid/ready channel interfaces for the header field parser.
// Depends on hhfp_pkg for the field types.
`default_nettype none

interface hhfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_start;

    modport source (output valid, output data_byte, output block_start, input ready);
    modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface hhfp_out_if;
    logic                 valid;
    logic                 ready;
    hhfp_pkg::kind_t      kind;
    hhfp_pkg::field_t     name_offset;
    hhfp_pkg::field_t     name_length;
    hhfp_pkg::field_t     value_offset;
    hhfp_pkg::field_t     value_length;

    modport source (output valid, output kind, output name_offset, output name_length,
                    output value_offset, output value_length, input ready);
    modport sink   (input valid, input kind, input name_offset, input name_length,
                    input value_offset, input value_length, output ready);
endinterface

`default_nettype wire

[rtl/core/http_header_field_parser.sv]
// HTTP header field parser: one header byte per word, one result per field, and one on block end or overflow.
// A byte is registered in the input stage, then its result in the output register; a full output register stalls it.
// Throughput: one byte per cycle while no result finds the output register full; the state loop runs through hhfp_step.
// Reset: rst_n clears parser state and both stage valids; parser begins a block.
// Depends on hhfp_pkg, hhfp_ifs and hhfp_step.
`default_nettype none

module http_header_field_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hhfp_in_if.sink         in_ch,
    hhfp_out_if.source      out_ch
);

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_start_reg;
    hhfp_pkg::parse_state_t state_reg;
    hhfp_pkg::parse_state_t state_next;
    logic                   step_res_valid;
    hhfp_pkg::result_t      step_res;
    logic                   out_valid_reg;
    hhfp_pkg::result_t      out_reg;
    logic                   s1_fire;
    logic                   in_fire;

    hhfp_step u_step (
        .state       (state_reg),
        .data_byte   (s1_byte_reg),
        .block_start (s1_start_reg),
        .state_next  (state_next),
        .res_valid   (step_res_valid),
        .res         (step_res)
    );

    // input stage moves on unless its result finds the output register full
    assign s1_fire = s1_valid_reg && (!step_res_valid || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire = in_ch.valid && in_ch.ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= hhfp_pkg::STATE_RESET;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (s1_fire)
                state_reg <= state_next;
            if (s1_fire && step_res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= in_ch.data_byte;
            s1_start_reg <= in_ch.block_start;
        end
        if (s1_fire && step_res_valid)
            out_reg <= step_res;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_reg.kind;
    assign out_ch.name_offset  = out_reg.name_offset;
    assign out_ch.name_length  = out_reg.name_length;
    assign out_ch.value_offset = out_reg.value_offset;
    assign out_ch.value_length = out_reg.value_length;

endmodule

`default_nettype wire

[rtl/core/hhfp_step.sv]
// Per-byte next-state and result logic of the header field parser.
// Depends on hhfp_pkg.
`default_nettype none

module hhfp_step (
    input  wire hhfp_pkg::parse_state_t state,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   block_start,
    output hhfp_pkg::parse_state_t      state_next,
    output logic                        res_valid,
    output hhfp_pkg::result_t           res
);

    always_comb
    begin
        hhfp_pkg::parse_state_t s;
        hhfp_pkg::pos_t         p;
        hhfp_pkg::pos_t         vlen;
        hhfp_pkg::pos_t         nlen;

        // a start mark restarts the parser on this word
        s = block_start ? hhfp_pkg::STATE_RESET : state;
        p = s.byte_position;
        vlen = '0;
        nlen = '0;
        res_valid = 1'b0;
        res = '0;
        state_next = s;

        if (s.phase == hhfp_pkg::PH_STOPPED)
        begin
            // hold until the next start mark
            state_next = s;
        end
        else if (p >= hhfp_pkg::pos_t'(hhfp_pkg::MAX_BLOCK_BYTES))
        begin
            state_next.phase = hhfp_pkg::PH_STOPPED;
            res_valid = 1'b1;
            res.kind = hhfp_pkg::KIND_OVERFLOW;
        end
        else
        begin
            if (s.phase == hhfp_pkg::PH_BEGIN)
            begin
                state_next.phase = hhfp_pkg::PH_NAME_BEGIN;
            end
            else
            begin
                // CR where a name would start ends the block
                if (state_next.phase == hhfp_pkg::PH_NEXT)
                begin
                    if (data_byte == hhfp_pkg::CHAR_CR)
                    begin
                        state_next.phase = hhfp_pkg::PH_STOPPED;
                        res_valid = 1'b1;
                        res.kind = hhfp_pkg::KIND_DONE;
                    end
                    else
                    begin
                        state_next.phase = hhfp_pkg::PH_NAME_BEGIN;
                    end
                end
                if (state_next.phase == hhfp_pkg::PH_NAME_BEGIN)
                begin
                    state_next.name_start = p;
                    state_next.phase = hhfp_pkg::PH_NAME;
                end
                // name runs to the colon, then optional whitespace
                if (state_next.phase == hhfp_pkg::PH_NAME)
                begin
                    if (data_byte == hhfp_pkg::CHAR_COLON)
                    begin
                        state_next.name_stop = p;
                        state_next.phase = hhfp_pkg::PH_OWS;
                    end
                end
                else if (state_next.phase == hhfp_pkg::PH_OWS)
                begin
                    if (data_byte != hhfp_pkg::CHAR_SPACE && data_byte != hhfp_pkg::CHAR_TAB)
                    begin
                        state_next.value_start = p;
                        state_next.phase = hhfp_pkg::PH_VALUE;
                    end
                end
                // value ends on LF right after CR
                if (state_next.phase == hhfp_pkg::PH_VALUE && s.prev_was_cr
                    && data_byte == hhfp_pkg::CHAR_LF)
                begin
                    if (p > state_next.value_start)
                        vlen = hhfp_pkg::pos_t'(p - state_next.value_start - hhfp_pkg::pos_t'(1));
                    if (state_next.name_stop >= state_next.name_start)
                        nlen = hhfp_pkg::pos_t'(state_next.name_stop - state_next.name_start);
                    res_valid = 1'b1;
                    res.kind = hhfp_pkg::KIND_FIELD;
                    res.name_offset = hhfp_pkg::to_field(state_next.name_start);
                    res.name_length = hhfp_pkg::to_field(nlen);
                    res.value_offset = hhfp_pkg::to_field(state_next.value_start);
                    res.value_length = hhfp_pkg::to_field(vlen);
                    state_next.phase = hhfp_pkg::PH_NEXT;
                end
            end
            state_next.prev_was_cr = (data_byte == hhfp_pkg::CHAR_CR);
            state_next.byte_position = hhfp_pkg::pos_t'(p + hhfp_pkg::pos_t'(1));
        end
    end

endmodule

`default_nettype wire
